### src/sorted_max_priority_queue_top_macros.svh
// Assertion macros for the sorted max-priority queue checker
`ifndef SORTED_MAX_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_TOP_MACROS_SVH

// Implication checked every clock, off during reset
`define SMPQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smpq check failed");

// Consequence checked on the clock after the antecedent
`define SMPQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smpq check failed");

`endif

### src/smpq_pkg.sv
// Package: types and constants of the sorted max-priority queue
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 5;

	localparam logic signed [DATA_W-1:0] EMPTY_TOP = -1;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POP_EMPTY  = 2'd1,
		ST_PUSH_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                     command;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic                     is_empty;
		logic [OUT_CNT_W-1:0]     entry_count;
		logic [1:0]               status;
	} out_t;

	// Broadcast to every cell in the row
	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic signed [DATA_W-1:0] value;
	} cell_op_t;

endpackage

`default_nettype wire

### src/smpq_cell.sv
// One storage cell of the sorted row: compare, insert and shift
`timescale 1ns / 1ps
`default_nettype none

module smpq_cell (
	input  wire logic                             clk,
	input  wire smpq_pkg::cell_op_t               op,
	input  wire logic                             occ,
	input  wire logic                             left_ins,
	input  wire logic signed [smpq_pkg::DATA_W-1:0] left_data,
	input  wire logic signed [smpq_pkg::DATA_W-1:0] right_data,
	output logic                                  ins,
	output logic signed [smpq_pkg::DATA_W-1:0]    data_q,
	output logic signed [smpq_pkg::DATA_W-1:0]    data_nxt
);

	// Row is kept largest first; new value lands in the first cell that
	// is free or holds a value not above it
	always_comb begin
		ins = !occ || (op.value >= data_q);
		data_nxt = data_q;
		if (op.pop) begin
			data_nxt = right_data;
		end else if (op.push) begin
			if (left_ins) begin
				data_nxt = left_data;
			end else if (ins) begin
				data_nxt = op.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.push || op.pop) begin
			data_q <= data_nxt;
		end
	end

endmodule

`default_nettype wire

### src/sorted_max_priority_queue_top.sv
// Top level: sorted max-priority queue built from a row of compare cells
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+---------------------------
//  input    | in_valid, in_ready, in_data      | command, value
//  output   | out_valid, out_ready, out_data   | top_value, is_empty,
//           |                                  | entry_count, status
//
// One transaction per cycle while in_ready is high: every cell compares
// against the pushed value in parallel, and a pop shifts the row by one
// cell in the same cycle. The result is registered on acceptance.
// in_ready drops only while a result waits and out_ready is low.
// Reset empties the queue at once; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_max_priority_queue_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire smpq_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output smpq_pkg::out_t      out_data
);

	localparam int N = smpq_pkg::CAPACITY;

	logic [smpq_pkg::CNT_W-1:0]            count_q;
	logic [smpq_pkg::CNT_W-1:0]            count_nxt;
	logic                                  out_valid_q;
	smpq_pkg::out_t                        out_data_q;
	logic                                  accept;
	logic                                  push_ok;
	logic                                  pop_ok;
	smpq_pkg::status_t                     status;
	smpq_pkg::cell_op_t                    op;
	logic [N-1:0]                          occ;
	logic [N-1:0]                          cell_ins;
	logic signed [smpq_pkg::DATA_W-1:0]    cell_data [N];
	logic signed [smpq_pkg::DATA_W-1:0]    cell_nxt [N];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		status  = smpq_pkg::ST_OK;
		if (accept) begin
			if (in_data.command == smpq_pkg::CMD_PUSH) begin
				if (count_q < smpq_pkg::CNT_W'(N)) begin
					push_ok = 1'b1;
				end else begin
					status = smpq_pkg::ST_PUSH_FULL;
				end
			end else begin
				if (count_q != '0) begin
					pop_ok = 1'b1;
				end else begin
					status = smpq_pkg::ST_POP_EMPTY;
				end
			end
		end
		count_nxt = count_q;
		if (push_ok) begin
			count_nxt = count_q + 1'b1;
		end else if (pop_ok) begin
			count_nxt = count_q - 1'b1;
		end
	end

	assign op.push  = push_ok;
	assign op.pop   = pop_ok;
	assign op.value = in_data.value;

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign occ[i] = count_q > smpq_pkg::CNT_W'(i);

		smpq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.occ        (occ[i]),
			.left_ins   ((i == 0) ? 1'b0 : cell_ins[(i == 0) ? 0 : i-1]),
			.left_data  (cell_data[(i == 0) ? 0 : i-1]),
			.right_data ((i == N-1) ? cell_data[i] : cell_data[(i == N-1) ? i : i+1]),
			.ins        (cell_ins[i]),
			.data_q     (cell_data[i]),
			.data_nxt   (cell_nxt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.top_value   <= (count_nxt == '0) ? smpq_pkg::EMPTY_TOP : cell_nxt[0];
			out_data_q.is_empty    <= (count_nxt == '0);
			out_data_q.entry_count <= smpq_pkg::OUT_CNT_W'(count_nxt);
			out_data_q.status      <= status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

### src/smpq_checker.sv
// Port-level checker for the sorted max-priority queue, bound to the top
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_max_priority_queue_top_macros.svh"

module smpq_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire smpq_pkg::in_t  in_data,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire smpq_pkg::out_t out_data
);

	`SMPQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`SMPQ_ASSERT_NXT(a_accept_gives_result, in_valid && in_ready && !$isunknown(in_data), out_valid)
	`SMPQ_ASSERT_IMP(a_empty_matches_count, out_valid, out_data.is_empty == (out_data.entry_count == '0))
	`SMPQ_ASSERT_IMP(a_empty_top, out_valid && out_data.is_empty, out_data.top_value == smpq_pkg::EMPTY_TOP)
	`SMPQ_ASSERT_IMP(a_pop_empty_flag, out_valid && out_data.status == smpq_pkg::ST_POP_EMPTY, out_data.is_empty)

endmodule

bind sorted_max_priority_queue_top smpq_checker u_smpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
